// File: rtl/core/split_impurity_from_dissimilarity_defines.svh
// Assertion macros shared by the split impurity RTL.
`ifndef SPLIT_IMPURITY_FROM_DISSIMILARITY_DEFINES_SVH
`define SPLIT_IMPURITY_FROM_DISSIMILARITY_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define SIFD_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("sifd assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define SIFD_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("sifd assertion failed");
`else
`define SIFD_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons)
`define SIFD_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif

`endif

// File: rtl/core/sifd_pkg.sv
// Shared field widths, opcodes and the microcode program of the split impurity block.
`timescale 1ns / 1ps

package sifd_pkg;

	// Field widths of the command and result items.
	localparam int OPCODE_W  = 1;
	localparam int IDX_W     = 6;
	localparam int DVAL_W    = 16;
	localparam int MASK_W    = 64;
	localparam int IMP_W     = 17;
	localparam int OBS_W     = 7;
	// Scaling of each term: a factor of two and sixteen fraction bits.
	localparam int QUO_SHIFT = 17;

	// Command opcodes.
	localparam logic [OPCODE_W-1:0] OPC_LOAD = 1'b0;
	localparam logic [OPCODE_W-1:0] OPC_EVAL = 1'b1;

	// Program counter width and step addresses.
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] PC_IDLE       = 4'd0;
	localparam logic [PC_W-1:0] PC_COUNT      = 4'd1;
	localparam logic [PC_W-1:0] PC_WALK_INIT  = 4'd2;
	localparam logic [PC_W-1:0] PC_WALK       = 4'd3;
	localparam logic [PC_W-1:0] PC_DRAIN      = 4'd4;
	localparam logic [PC_W-1:0] PC_SETUP_L    = 4'd5;
	localparam logic [PC_W-1:0] PC_DIV_L      = 4'd6;
	localparam logic [PC_W-1:0] PC_SAVE_L     = 4'd7;
	localparam logic [PC_W-1:0] PC_SETUP_R    = 4'd8;
	localparam logic [PC_W-1:0] PC_DIV_R      = 4'd9;
	localparam logic [PC_W-1:0] PC_EMIT       = 4'd10;
	localparam logic [PC_W-1:0] PC_EMIT_RET   = 4'd11;
	localparam logic [PC_W-1:0] PC_DEGEN      = 4'd12;
	localparam logic [PC_W-1:0] PC_DEGEN_RET  = 4'd13;

	// Datapath operation of one step.
	typedef enum logic [3:0] {
		UOP_NONE,
		UOP_COUNT,
		UOP_WALK_INIT,
		UOP_WALK,
		UOP_SETUP_L,
		UOP_DIV,
		UOP_SAVE_L,
		UOP_SETUP_R,
		UOP_EMIT,
		UOP_EMIT_DEGEN
	} uop_t;

	// Jump condition of one step; when false the counter steps on by one.
	typedef enum logic [2:0] {
		JC_NEVER,
		JC_ALWAYS,
		JC_NO_EVAL,
		JC_COUNT_MORE,
		JC_DEGEN,
		JC_WALK_MORE,
		JC_DIV_MORE,
		JC_OUT_BUSY
	} jcond_t;

	typedef struct packed {
		uop_t            uop;
		jcond_t          jcond;
		logic [PC_W-1:0] target;
	} ucode_t;

	// The control program, one word per step.
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		case (pc)
			PC_IDLE:      w = '{UOP_NONE,       JC_NO_EVAL,    PC_IDLE};
			PC_COUNT:     w = '{UOP_COUNT,      JC_COUNT_MORE, PC_COUNT};
			PC_WALK_INIT: w = '{UOP_WALK_INIT,  JC_DEGEN,      PC_DEGEN};
			PC_WALK:      w = '{UOP_WALK,       JC_WALK_MORE,  PC_WALK};
			PC_DRAIN:     w = '{UOP_NONE,       JC_NEVER,      PC_IDLE};
			PC_SETUP_L:   w = '{UOP_SETUP_L,    JC_NEVER,      PC_IDLE};
			PC_DIV_L:     w = '{UOP_DIV,        JC_DIV_MORE,   PC_DIV_L};
			PC_SAVE_L:    w = '{UOP_SAVE_L,     JC_NEVER,      PC_IDLE};
			PC_SETUP_R:   w = '{UOP_SETUP_R,    JC_NEVER,      PC_IDLE};
			PC_DIV_R:     w = '{UOP_DIV,        JC_DIV_MORE,   PC_DIV_R};
			PC_EMIT:      w = '{UOP_EMIT,       JC_OUT_BUSY,   PC_EMIT};
			PC_EMIT_RET:  w = '{UOP_NONE,       JC_ALWAYS,     PC_IDLE};
			PC_DEGEN:     w = '{UOP_EMIT_DEGEN, JC_OUT_BUSY,   PC_DEGEN};
			PC_DEGEN_RET: w = '{UOP_NONE,       JC_ALWAYS,     PC_IDLE};
			default:      w = '{UOP_NONE,       JC_ALWAYS,     PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

// File: rtl/core/sifd_cmd_if.sv
// Command channel: valid, ready and the fields of one command item.
`timescale 1ns / 1ps

interface sifd_cmd_if import sifd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [IDX_W-1:0]    row_index;
	logic [IDX_W-1:0]    col_index;
	logic [DVAL_W-1:0]   dissim_value;
	logic [MASK_W-1:0]   split_mask;

	modport source (
		output valid, opcode, row_index, col_index, dissim_value, split_mask,
		input  ready
	);
	modport sink (
		input  valid, opcode, row_index, col_index, dissim_value, split_mask,
		output ready
	);
endinterface

// File: rtl/core/sifd_res_if.sv
// Result channel: valid, ready and the fields of one result item.
`timescale 1ns / 1ps

interface sifd_res_if import sifd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IMP_W-1:0] impurity;
	logic             degenerate;

	modport source (
		output valid, impurity, degenerate,
		input  ready
	);
	modport sink (
		input  valid, impurity, degenerate,
		output ready
	);
endinterface

// File: rtl/core/sifd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module sifd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/core/split_impurity_from_dissimilarity.sv
// Top level: microcoded split impurity evaluator over a stored dissimilarity triangle.
`timescale 1ns / 1ps
`include "split_impurity_from_dissimilarity_defines.svh"

// Usage
// The cmd channel takes two kinds of item. A load item (opcode 0) writes one
// upper-triangle dissimilarity entry into the on-chip RAM and gives
// no result. An evaluate item (opcode 1) carries a split mask and gives exactly
// one item on the res channel: the impurity in Q1.16, or the degenerate flag with
// impurity zero when either group has fewer than two members.
// cfg_wr_en with cfg_wr_data sets the observation count n (reset value 64).
// An evaluate runs a short microprogram: it counts the groups, takes a set-up
// step, walks the stored pairs through the single RAM read port, drains the
// last read, then runs two restoring divisions, each after a set-up step, and
// keeps the left term between them. A degenerate split skips the walk and the
// divisions. Either result is held back while the output register is full,
// and the next item is taken once the sequencer is back in idle, where loads
// are taken back to back.
// A finished result sits in an output register; further items are accepted while
// it waits, and the next result is held back until res.ready takes the first.
// Reset clears the sequencer and the result valid flag; RAM contents are undefined
// until written, so every pair an evaluate reads must have been loaded first.
module split_impurity_from_dissimilarity import sifd_pkg::*; #(
	parameter int MAX_OBS    = 64,
	parameter int VALUE_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [OBS_W-1:0] cfg_wr_data,
	sifd_cmd_if.sink         cmd,
	sifd_res_if.source       res
);

	localparam int NW    = $clog2(MAX_OBS + 1);
	localparam int IW    = $clog2(MAX_OBS);
	localparam int AW    = $clog2(MAX_OBS * MAX_OBS);
	localparam int PAIRS = MAX_OBS * (MAX_OBS - 1) / 2;
	localparam int SUM_W = VALUE_BITS + $clog2(PAIRS + 1);
	localparam int DEN_W = $clog2(MAX_OBS * (MAX_OBS - 1) + 1);
	localparam int NUM_W = SUM_W + QUO_SHIFT;
	localparam int DCW   = $clog2(NUM_W);

	// Control state.
	logic [PC_W-1:0]  pc_q;
	logic [OBS_W-1:0] obs_count_q;
	logic             res_valid_q;
	logic             rd_valid_s1;

	// Datapath registers.
	logic [MAX_OBS-1:0] mask_q;
	logic [IW-1:0]      cnt_q;
	logic [NW-1:0]      nl_q;
	logic [NW-1:0]      nr_q;
	logic [IW-1:0]      i_q;
	logic [IW-1:0]      k_q;
	logic [SUM_W-1:0]   suml_q;
	logic [SUM_W-1:0]   sumr_q;
	logic               same_s1;
	logic               left_s1;
	logic [DEN_W-1:0]   den_q;
	logic [NUM_W-1:0]   num_q;
	logic [DEN_W-1:0]   rem_q;
	logic [IMP_W-1:0]   quo_q;
	logic [DCW-1:0]     div_cnt_q;
	logic [IMP_W-1:0]   term_l_q;
	logic [IMP_W-1:0]   impurity_q;
	logic               degenerate_q;

	// Combinational signals.
	ucode_t           uc;
	logic             jump;
	logic             cmd_acc;
	logic             eval_acc;
	logic             load_ok;
	logic             res_busy;
	logic             emit_go;
	logic [NW-1:0]    n_w;
	logic             walk_last;
	logic             row_end;
	logic [NW-1:0]    sel_cnt;
	logic [SUM_W-1:0] sel_sum;
	logic [2*NW-1:0]  prod_w;
	logic [DEN_W:0]   rem_trial;
	logic             rem_ge;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [VALUE_BITS-1:0] ram_wdata;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [VALUE_BITS-1:0] ram_rdata;

	// Effective observation count, limited to the array size.
	assign n_w = (obs_count_q > OBS_W'(MAX_OBS)) ? NW'(MAX_OBS) : NW'(obs_count_q);

	// Handshakes.
	assign cmd.ready = (pc_q == PC_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign eval_acc  = cmd_acc && (cmd.opcode == OPC_EVAL);
	assign res_busy  = res_valid_q && !res.ready;

	// Current control word.
	assign uc = ucode_rom(pc_q);

	// Walk position: end of a row and the final pair of the triangle.
	assign row_end   = (NW'(k_q) == n_w - NW'(1));
	assign walk_last = row_end && (NW'(i_q) == n_w - NW'(2));

	// Jump condition evaluation.
	always_comb begin
		case (uc.jcond)
			JC_NEVER:      jump = 1'b0;
			JC_ALWAYS:     jump = 1'b1;
			JC_NO_EVAL:    jump = !eval_acc;
			JC_COUNT_MORE: jump = (cnt_q != IW'(MAX_OBS - 1));
			JC_DEGEN:      jump = (nl_q < NW'(2)) || (nr_q < NW'(2));
			JC_WALK_MORE:  jump = !walk_last;
			JC_DIV_MORE:   jump = (div_cnt_q != '0);
			JC_OUT_BUSY:   jump = res_busy;
			default:       jump = 1'b0;
		endcase
	end

	// Step counter, configuration register and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_IDLE;
			obs_count_q <= OBS_W'(64);
			res_valid_q <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			pc_q        <= jump ? uc.target : pc_q + PC_W'(1);
			rd_valid_s1 <= (uc.uop == UOP_WALK);
			if (cfg_wr_en) begin
				obs_count_q <= cfg_wr_data;
			end
			if (emit_go) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Dissimilarity store: loads write, the pair walk reads.
	assign load_ok   = (cmd.row_index < cmd.col_index) &&
	                   ((IDX_W + 1)'(cmd.col_index) < (IDX_W + 1)'(MAX_OBS));
	assign ram_we    = cmd_acc && (cmd.opcode == OPC_LOAD) && load_ok;
	assign ram_waddr = AW'(cmd.row_index) * AW'(MAX_OBS) + AW'(cmd.col_index);
	assign ram_wdata = VALUE_BITS'(cmd.dissim_value);
	assign ram_re    = (uc.uop == UOP_WALK);
	assign ram_raddr = AW'(i_q) * AW'(MAX_OBS) + AW'(k_q);

	sifd_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (MAX_OBS * MAX_OBS)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// Group selection and shared multiplier for the term denominators.
	assign sel_cnt = (uc.uop == UOP_SETUP_L) ? nl_q : nr_q;
	assign sel_sum = (uc.uop == UOP_SETUP_L) ? suml_q : sumr_q;
	assign prod_w  = (2 * NW)'(n_w) * (2 * NW)'(sel_cnt - NW'(1));

	// One restoring division step.
	assign rem_trial = {rem_q, num_q[NUM_W-1]};
	assign rem_ge    = (rem_trial >= {1'b0, den_q});

	assign emit_go = ((uc.uop == UOP_EMIT) || (uc.uop == UOP_EMIT_DEGEN)) && !res_busy;

	// Datapath driven by the control word.
	always_ff @(posedge clk) begin
		if (eval_acc) begin
			mask_q <= cmd.split_mask[MAX_OBS-1:0];
			cnt_q  <= '0;
			nl_q   <= '0;
			nr_q   <= '0;
		end

		// Group count, one observation a cycle.
		if (uc.uop == UOP_COUNT) begin
			cnt_q <= cnt_q + IW'(1);
			if (NW'(cnt_q) < n_w) begin
				if (mask_q[cnt_q]) begin
					nl_q <= nl_q + NW'(1);
				end else begin
					nr_q <= nr_q + NW'(1);
				end
			end
		end

		// Pair walk over the upper triangle.
		if (uc.uop == UOP_WALK_INIT) begin
			i_q <= '0;
			k_q <= IW'(1);
		end else if (uc.uop == UOP_WALK) begin
			same_s1 <= (mask_q[i_q] == mask_q[k_q]);
			left_s1 <= mask_q[i_q];
			if (row_end) begin
				i_q <= i_q + IW'(1);
				k_q <= i_q + IW'(2);
			end else begin
				k_q <= k_q + IW'(1);
			end
		end

		// Within-group sums, accumulated in the cycle after the read.
		if (uc.uop == UOP_WALK_INIT) begin
			suml_q <= '0;
			sumr_q <= '0;
		end else if (rd_valid_s1 && same_s1) begin
			if (left_s1) begin
				suml_q <= suml_q + SUM_W'(ram_rdata);
			end else begin
				sumr_q <= sumr_q + SUM_W'(ram_rdata);
			end
		end

		// Divider set-up and iteration.
		if ((uc.uop == UOP_SETUP_L) || (uc.uop == UOP_SETUP_R)) begin
			den_q     <= DEN_W'(prod_w);
			num_q     <= {sel_sum, {QUO_SHIFT{1'b0}}} >> VALUE_BITS;
			rem_q     <= '0;
			quo_q     <= '0;
			div_cnt_q <= DCW'(NUM_W - 1);
		end else if (uc.uop == UOP_DIV) begin
			rem_q     <= rem_ge ? DEN_W'(rem_trial - {1'b0, den_q}) : DEN_W'(rem_trial);
			num_q     <= num_q << 1;
			quo_q     <= {quo_q[IMP_W-2:0], rem_ge};
			div_cnt_q <= div_cnt_q - DCW'(1);
		end

		if (uc.uop == UOP_SAVE_L) begin
			term_l_q <= quo_q;
		end

		// Result register.
		if (emit_go) begin
			if (uc.uop == UOP_EMIT_DEGEN) begin
				impurity_q   <= '0;
				degenerate_q <= 1'b1;
			end else begin
				impurity_q   <= IMP_W'({1'b0, term_l_q} + {1'b0, quo_q});
				degenerate_q <= 1'b0;
			end
		end
	end

	assign res.valid      = res_valid_q;
	assign res.impurity   = impurity_q;
	assign res.degenerate = degenerate_q;

	// An accepted evaluate starts the group count in the next cycle.
	`SIFD_ASSERT_NEXT(a_eval_starts, clk, arst_n, eval_acc, pc_q == PC_COUNT)
	// The walk only visits pairs with row below column inside the node.
	`SIFD_ASSERT_IMPL(a_walk_bounds, clk, arst_n, uc.uop == UOP_WALK, (i_q < k_q) && (NW'(k_q) < n_w))
	// The partial remainder stays below the divisor throughout a division.
	`SIFD_ASSERT_IMPL(a_rem_below_den, clk, arst_n, uc.uop == UOP_DIV, rem_q < den_q)
	// A degenerate result always carries zero impurity.
	`SIFD_ASSERT_IMPL(a_degen_zero, clk, arst_n, res_valid_q && degenerate_q, impurity_q == '0)

endmodule
